// ===== rtl/ish_pkg.sv =====
// Shared types, codes and helpers for the interval spacing histogram.
// Depends on nothing; every other file of the block imports it.
package ish_pkg;

   localparam int LEVELS_DEF = 5;
   localparam int BINS_DEF   = 256;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_INTERVAL     = 2'd0,
      CMD_READ_BIN     = 2'd1,
      CMD_READ_SUMMARY = 2'd2
   } cmd_type;

   localparam logic [1:0] STAT_DIST   = 2'd0;
   localparam logic [1:0] STAT_LEN    = 2'd1;
   localparam logic [1:0] STAT_OVL    = 2'd2;
   localparam logic [1:0] STAT_UNUSED = 2'd3;

   localparam logic [2:0] KIND_OVF_DIST = 3'd0;
   localparam logic [2:0] KIND_OVF_LEN  = 3'd1;
   localparam logic [2:0] KIND_OVF_OVL  = 3'd2;
   localparam logic [2:0] KIND_BIN      = 3'd3;
   localparam logic [2:0] KIND_SUMMARY  = 3'd4;

   // Control of one histogram memory.
   typedef struct packed {
      logic rd;
      logic inc;
      logic clr;
   } bank_ctl_type;

   // All result words caused by one item.
   typedef struct packed {
      logic [1:0]  count;
      logic [2:0]  kind0;
      logic [2:0]  kind1;
      logic [2:0]  kind2;
      logic [31:0] value0;
      logic [31:0] value1;
      logic [31:0] value2;
      logic [31:0] max_value;
      logic [31:0] contig_total;
   } bundle_type;

   function automatic logic [31:0] sat_add(input logic [31:0] v, input logic [1:0] a);
      logic [32:0] sum;
      sum = {1'b0, v} + {31'b0, a};
      return sum[32] ? ALL_ONES : sum[31:0];
   endfunction

endpackage

// ===== rtl/ish_if.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on ish_pkg.
interface ish_req_if;
   import ish_pkg::*;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [2:0]  level;
   logic [31:0] start_req;
   logic [31:0] span;
   logic        first_of_list;
   logic        last_of_list;
   logic [1:0]  stat_kind;
   logic [7:0]  bin_index;
   modport source (output valid, cmd, level, start_req, span, first_of_list,
                   last_of_list, stat_kind, bin_index, input ready);
   modport sink   (input valid, cmd, level, start_req, span, first_of_list,
                   last_of_list, stat_kind, bin_index, output ready);
endinterface

interface ish_rsp_if;
   import ish_pkg::*;
   logic        valid;
   logic        ready;
   logic [2:0]  result_kind;
   logic [31:0] value;
   logic [31:0] max_value;
   logic [31:0] contig_total;
   logic        last_of_run;
   modport source (output valid, result_kind, value, max_value, contig_total,
                   last_of_run, input ready);
   modport sink   (input valid, result_kind, value, max_value, contig_total,
                   last_of_run, output ready);
endinterface

// ===== rtl/interval_spacing_histogram_top.sv =====
// Interval spacing histogram top level: decode, extremes, counters, result queue.
// Depends on ish_pkg, ish_if (ish_req_if, ish_rsp_if) and ish_bank.
//
// The block accepts one request word per clock cycle while ready is high. An
// interval word passes a three-stage pipeline: distance and overlap are formed
// at acceptance, the three histogram memories are read in the second stage,
// and the incremented counts are written back in the third, with forwarding
// of the last write so that consecutive hits on the same bin count correctly.
// Results (0 to 3 per word) enter a four-deep queue and leave on the response
// channel one word per cycle while it is ready; an item yielding three overflow
// results therefore occupies the response side until all three are taken, and
// the request side also backs off when the queue and words still in the pipeline
// could fill it. After reset the block zeroes the histogram memories, one entry
// per cycle in all three at once, and does not accept words meanwhile.
module interval_spacing_histogram_top #(
   parameter int LEVELS = ish_pkg::LEVELS_DEF,
   parameter int BINS   = ish_pkg::BINS_DEF
) (
   input logic       clock,
   input logic       reset,
   ish_req_if.sink   req_chan,
   ish_rsp_if.source rsp_chan
);
   import ish_pkg::*;

   localparam int DEPTH = LEVELS * BINS;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int FQ    = 4;
   localparam int FPW   = $clog2(FQ);

   // Clearing pass after reset.
   logic          clr_busy_ff;
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Stage 0: acceptance. The previous interval and the list overlap flag
   // advance here so the next word sees them at once.
   logic        accept;
   logic        lvl_ok0, is_int0, ov0, ovf0, lo_mid, bonus;
   logic [31:0] prev_start_ff, prev_end_ff;
   logic        lo_ff;

   assign accept  = req_chan.valid && req_chan.ready;
   assign lvl_ok0 = 32'(req_chan.level) < LEVELS;
   assign is_int0 = (req_chan.cmd == CMD_INTERVAL) && lvl_ok0;
   assign ov0     = req_chan.start_req <= prev_end_ff;
   assign ovf0    = !req_chan.first_of_list && ov0;
   assign lo_mid  = req_chan.first_of_list ? 1'b0 : (lo_ff || ov0);
   assign bonus   = req_chan.last_of_list && lo_mid;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_start_ff <= '0;
         prev_end_ff   <= '0;
         lo_ff         <= 1'b0;
      end else if (accept && is_int0) begin
         prev_start_ff <= req_chan.start_req;
         prev_end_ff   <= req_chan.start_req + req_chan.span;
         lo_ff         <= req_chan.last_of_list ? 1'b0 : lo_mid;
      end
   end

   logic        s1_valid_ff, s1_lvl_ok_ff, s1_first_ff, s1_ov_ff;
   logic [1:0]  s1_cmd_ff, s1_sk_ff, s1_add_ff;
   logic [2:0]  s1_lvl_ff;
   logic [7:0]  s1_bi_ff;
   logic [31:0] s1_dist_ff, s1_span_ff, s1_ovl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_cmd_ff    <= req_chan.cmd;
      s1_lvl_ff    <= req_chan.level;
      s1_lvl_ok_ff <= lvl_ok0;
      s1_first_ff  <= req_chan.first_of_list;
      s1_ov_ff     <= ovf0;
      s1_add_ff    <= {1'b0, ovf0} + {1'b0, bonus};
      s1_sk_ff     <= req_chan.stat_kind;
      s1_bi_ff     <= req_chan.bin_index;
      s1_dist_ff   <= req_chan.start_req - prev_start_ff;
      s1_span_ff   <= req_chan.span;
      s1_ovl_ff    <= prev_end_ff - req_chan.start_req;
   end

   // Stage 1: memory read issue, extremes and contiguous count.
   logic          int1, binrd1, in_d, in_l, in_o;
   logic [31:0]   base32;
   logic [AW-1:0] a_d, a_l, a_o, a_bi;
   logic [LW-1:0] lvl_idx;
   bank_ctl_type  ctl_d, ctl_l, ctl_o;
   logic [AW-1:0] addr_d, addr_l, addr_o;

   assign int1    = s1_valid_ff && s1_cmd_ff == CMD_INTERVAL && s1_lvl_ok_ff;
   assign binrd1  = s1_valid_ff && s1_cmd_ff == CMD_READ_BIN && s1_lvl_ok_ff
                    && 32'(s1_bi_ff) < BINS;
   assign in_d    = s1_dist_ff < BINS;
   assign in_l    = s1_span_ff < BINS;
   assign in_o    = s1_ovl_ff < BINS;
   assign base32  = 32'(s1_lvl_ff) * 32'(BINS);
   assign a_d     = AW'(base32 + s1_dist_ff);
   assign a_l     = AW'(base32 + s1_span_ff);
   assign a_o     = AW'(base32 + s1_ovl_ff);
   assign a_bi    = AW'(base32 + 32'(s1_bi_ff));
   assign lvl_idx = LW'(s1_lvl_ff);

   always_comb begin
      ctl_d.clr = clr_busy_ff;
      ctl_l.clr = clr_busy_ff;
      ctl_o.clr = clr_busy_ff;
      ctl_d.inc = int1 && !s1_first_ff && in_d;
      ctl_l.inc = int1 && in_l;
      ctl_o.inc = int1 && !s1_first_ff && s1_ov_ff && in_o;
      ctl_d.rd  = ctl_d.inc || (binrd1 && s1_sk_ff == STAT_DIST);
      ctl_l.rd  = ctl_l.inc || (binrd1 && s1_sk_ff == STAT_LEN);
      ctl_o.rd  = ctl_o.inc || (binrd1 && s1_sk_ff == STAT_OVL);
      if (clr_busy_ff) begin
         addr_d = clr_addr_ff;
         addr_l = clr_addr_ff;
         addr_o = clr_addr_ff;
      end else if (s1_cmd_ff == CMD_READ_BIN) begin
         addr_d = a_bi;
         addr_l = a_bi;
         addr_o = a_bi;
      end else begin
         addr_d = a_d;
         addr_l = a_l;
         addr_o = a_o;
      end
   end

   logic [31:0] cnt_d, cnt_l, cnt_o;

   ish_bank #(.DEPTH(DEPTH)) u_bank_dist (
      .clock(clock), .reset(reset), .ctl(ctl_d), .addr(addr_d), .count(cnt_d));
   ish_bank #(.DEPTH(DEPTH)) u_bank_len (
      .clock(clock), .reset(reset), .ctl(ctl_l), .addr(addr_l), .count(cnt_l));
   ish_bank #(.DEPTH(DEPTH)) u_bank_ovl (
      .clock(clock), .reset(reset), .ctl(ctl_o), .addr(addr_o), .count(cnt_o));

   // Per-level extremes and contiguous counts, one row touched per cycle.
   logic [31:0] min_ff [0:2][0:LEVELS-1];
   logic [31:0] max_ff [0:2][0:LEVELS-1];
   logic [31:0] contig_ff [0:LEVELS-1];
   logic [31:0] row_min [0:2];
   logic [31:0] row_max [0:2];
   logic [31:0] row_val [0:2];
   logic [2:0]  row_upd;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         row_min[k] = min_ff[k][lvl_idx];
         row_max[k] = max_ff[k][lvl_idx];
      end
      row_val[0] = s1_dist_ff;
      row_val[1] = s1_span_ff;
      row_val[2] = s1_ovl_ff;
      row_upd[0] = int1 && !s1_first_ff;
      row_upd[1] = int1 && !s1_first_ff;
      row_upd[2] = int1 && !s1_first_ff && s1_ov_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LEVELS; l++) begin
            for (int k = 0; k < 3; k++) begin
               min_ff[k][l] <= ALL_ONES;
               max_ff[k][l] <= '0;
            end
            contig_ff[l] <= '0;
         end
      end else begin
         for (int k = 0; k < 3; k++) begin
            if (row_upd[k] && row_val[k] < row_min[k]) begin
               min_ff[k][lvl_idx] <= row_val[k];
            end
            if (row_upd[k] && row_val[k] > row_max[k]) begin
               max_ff[k][lvl_idx] <= row_val[k];
            end
         end
         if (int1) begin
            contig_ff[lvl_idx] <= sat_add(contig_ff[lvl_idx], s1_add_ff);
         end
      end
   end

   // Intervals give only overflows, as distance, length, overlap; reads give one.
   logic       e_d, e_l, e_o;
   bundle_type b1;

   assign e_d = !s1_first_ff && !in_d;
   assign e_l = !in_l;
   assign e_o = !s1_first_ff && s1_ov_ff && !in_o;

   always_comb begin
      b1 = '0;
      if (s1_cmd_ff == CMD_INTERVAL && s1_lvl_ok_ff) begin
         b1.count  = {1'b0, e_d} + {1'b0, e_l} + {1'b0, e_o};
         b1.kind0  = e_d ? KIND_OVF_DIST : (e_l ? KIND_OVF_LEN : KIND_OVF_OVL);
         b1.value0 = e_d ? s1_dist_ff : (e_l ? s1_span_ff : s1_ovl_ff);
         b1.kind1  = (e_d && e_l) ? KIND_OVF_LEN : KIND_OVF_OVL;
         b1.value1 = (e_d && e_l) ? s1_span_ff : s1_ovl_ff;
         b1.kind2  = KIND_OVF_OVL;
         b1.value2 = s1_ovl_ff;
      end else if (s1_cmd_ff == CMD_READ_BIN) begin
         b1.count = 2'd1;
         b1.kind0 = KIND_BIN;
      end else if (s1_cmd_ff == CMD_READ_SUMMARY) begin
         b1.count  = 2'd1;
         b1.kind0  = KIND_SUMMARY;
         b1.value0 = ALL_ONES;
         if (s1_lvl_ok_ff) begin
            b1.contig_total = contig_ff[lvl_idx];
            if (s1_sk_ff != STAT_UNUSED) begin
               b1.value0    = row_min[s1_sk_ff];
               b1.max_value = row_max[s1_sk_ff];
            end
         end
      end
   end

   // Stage 2: bin count arrives from the memory; the bundle is queued.
   logic       s2_valid_ff, s2_binrd_ff;
   logic [1:0] s2_sk_ff;
   bundle_type s2_bundle_ff, b2;
   logic       push;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_bundle_ff <= b1;
      s2_binrd_ff  <= binrd1 && s1_sk_ff != STAT_UNUSED;
      s2_sk_ff     <= s1_sk_ff;
   end

   always_comb begin
      b2 = s2_bundle_ff;
      if (s2_binrd_ff) begin
         case (s2_sk_ff)
            STAT_DIST: b2.value0 = cnt_d;
            STAT_LEN:  b2.value0 = cnt_l;
            default:   b2.value0 = cnt_o;
         endcase
      end
   end

   assign push = s2_valid_ff && s2_bundle_ff.count != 2'd0;

   // Result queue and serializer.
   bundle_type     fifo_ff [0:FQ-1];
   logic [FPW-1:0] wptr_ff, rptr_ff;
   logic [FPW:0]   cnt_ff;
   logic [1:0]     idx_ff;
   bundle_type     head;
   logic           word_last, pop;
   logic [FPW+1:0] occupancy;

   assign head      = fifo_ff[rptr_ff];
   assign word_last = idx_ff == head.count - 2'd1;
   assign pop       = rsp_chan.valid && rsp_chan.ready && word_last;
   assign occupancy = {1'b0, cnt_ff} + {{(FPW+1){1'b0}}, s1_valid_ff}
                      + {{(FPW+1){1'b0}}, s2_valid_ff};

   assign req_chan.ready = !clr_busy_ff && occupancy < (FPW+2)'(FQ);

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wptr_ff] <= b2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
         idx_ff  <= '0;
      end else begin
         if (push) begin
            wptr_ff <= wptr_ff + FPW'(1);
         end
         if (pop) begin
            rptr_ff <= rptr_ff + FPW'(1);
            idx_ff  <= '0;
         end else if (rsp_chan.valid && rsp_chan.ready) begin
            idx_ff <= idx_ff + 2'd1;
         end
         cnt_ff <= cnt_ff + (FPW+1)'(push) - (FPW+1)'(pop);
      end
   end

   always_comb begin
      rsp_chan.valid        = cnt_ff != '0;
      rsp_chan.max_value    = head.max_value;
      rsp_chan.contig_total = head.contig_total;
      rsp_chan.last_of_run  = word_last;
      case (idx_ff)
         2'd0: begin
            rsp_chan.result_kind = head.kind0;
            rsp_chan.value       = head.value0;
         end
         2'd1: begin
            rsp_chan.result_kind = head.kind1;
            rsp_chan.value       = head.value1;
         end
         default: begin
            rsp_chan.result_kind = head.kind2;
            rsp_chan.value       = head.value2;
         end
      endcase
   end

   // No word enters while the memories are being zeroed.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      accept |-> !clr_busy_ff)
      else $error("word accepted during clearing pass");

   // A bundle leaving stage two always finds room in the queue.
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff < (FPW+1)'(FQ)) || pop)
      else $error("result queue overflow");

   // Memory increments only happen with the pipeline running, never in clearing.
   a_no_inc_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !s1_valid_ff && !s2_valid_ff)
      else $error("pipeline active during clearing pass");

   // The queue count follows pushes and pops exactly.
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      ##1 cnt_ff == $past(cnt_ff) + (FPW+1)'($past(push)) - (FPW+1)'($past(pop)))
      else $error("queue count mismatch");

endmodule

// ===== rtl/ish_bank.sv =====
// One histogram memory: registered read, saturating increment, write-back.
// Depends on ish_pkg.
module ish_bank #(
   parameter int DEPTH = ish_pkg::LEVELS_DEF * ish_pkg::BINS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ish_pkg::bank_ctl_type        ctl,
   input  logic [$clog2(DEPTH)-1:0]     addr,
   output logic [31:0]                  count
);
   import ish_pkg::*;
   localparam int AW = $clog2(DEPTH);

   logic [31:0]   mem [0:DEPTH-1];
   logic [31:0]   rdata_ff;
   logic          s2_inc_ff, lw_valid_ff;
   logic [AW-1:0] s2_addr_ff, lw_addr_ff;
   logic [31:0]   lw_data_ff;
   logic [31:0]   cur, upd;

   // The word written last cycle is not yet visible in the read data.
   assign cur   = (lw_valid_ff && lw_addr_ff == s2_addr_ff) ? lw_data_ff : rdata_ff;
   assign upd   = sat_add(cur, 2'd1);
   assign count = cur;

   always_ff @(posedge clock) begin
      if (ctl.clr) begin
         mem[addr] <= '0;
      end else if (s2_inc_ff) begin
         mem[s2_addr_ff] <= upd;
      end
      if (ctl.rd) begin
         rdata_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_inc_ff   <= 1'b0;
         lw_valid_ff <= 1'b0;
      end else begin
         s2_inc_ff   <= ctl.inc;
         lw_valid_ff <= s2_inc_ff;
      end
      s2_addr_ff <= addr;
      lw_addr_ff <= s2_addr_ff;
      lw_data_ff <= upd;
   end

endmodule
